@@ rtl/mflc_pkg.sv @@
package mflc_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned BAT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_TICK  = 2'd0;
  localparam func_t FUNC_START = 2'd1;
  localparam func_t FUNC_STOP  = 2'd2;
  localparam func_t FUNC_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MS    = 2'd1;

  localparam logic [CNT_W-1:0]  DEBOUNCE_TICKS_RST = 8'd2;
  localparam logic [TIME_W-1:0] BOUNDARY_MS_RST    = 16'd30;

  typedef struct packed {
    func_t              func;
    logic               motor_running;
    logic               under_volt;
    logic               over_volt;
    logic               fault_low;
    logic [BAT_W-1:0]   battery_sample;
  } in_item_t;

  typedef struct packed {
    logic               overcurrent_fault;
    logic               open_load;
    logic [TIME_W-1:0]  latency_ms;
    logic [BAT_W-1:0]   battery_at_fault;
    logic               fault_active;
  } out_item_t;

endpackage

@@ rtl/mflc_ifs.sv @@
interface mflc_in_if
  import mflc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  func_t              func;
  logic               motor_running;
  logic               under_volt;
  logic               over_volt;
  logic               fault_low;
  logic [BAT_W-1:0]   battery_sample;

  modport source (output valid, func, motor_running, under_volt, over_volt, fault_low,
                  battery_sample, input ready);
  modport sink (input valid, func, motor_running, under_volt, over_volt, fault_low,
                battery_sample, output ready);
endinterface

interface mflc_out_if
  import mflc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               overcurrent_fault;
  logic               open_load;
  logic [TIME_W-1:0]  latency_ms;
  logic [BAT_W-1:0]   battery_at_fault;
  logic               fault_active;

  modport source (output valid, overcurrent_fault, open_load, latency_ms, battery_at_fault,
                  fault_active, input ready);
  modport sink (input valid, overcurrent_fault, open_load, latency_ms, battery_at_fault,
                fault_active, output ready);
endinterface

interface mflc_cfg_if
  import mflc_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   idx;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

@@ rtl/motor_fault_latency_classifier.sv @@
// Motor driver fault latency classifier. Each input transfer is a millisecond
// tick or a motor start/stop/clear event, and every one of them yields exactly
// one result transfer showing the classification state after that item. The
// block is a two-register pass: an input register and a result register with
// the flag and counter update between them, so one item is taken every clock
// unless a waiting result holds the flow, and each result is registered in the
// result register after its item has passed the input register. While a result
// waits to be taken, input is still accepted as long as the input register is
// empty; a full one behind a waiting result stalls the input. Configuration
// (debounce_ticks at index 0, boundary_ms at index 1) is always ready and must
// be written while no item is in flight; writes to other indexes are dropped.
module motor_fault_latency_classifier
  import mflc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mflc_in_if.sink    in_ch,
  mflc_out_if.source out_ch,
  mflc_cfg_if.sink   cfg_ch
);

  logic [CNT_W-1:0]  debounce_ticks_r;
  logic [TIME_W-1:0] boundary_ms_r;

  logic              confirmed_r, confirmed_nxt;
  logic [CNT_W-1:0]  debounce_count_r, debounce_count_nxt;
  logic              judged_r, judged_nxt;
  logic              oc_flag_r, oc_flag_nxt;
  logic              ol_flag_r, ol_flag_nxt;
  logic [TIME_W-1:0] latency_r, latency_nxt;
  logic [BAT_W-1:0]  battery_r, battery_nxt;
  logic [TIME_W-1:0] run_time_r, run_time_nxt;
  logic              run_enable_r, run_enable_nxt;

  in_item_t          in_r;
  logic              in_valid_r;
  out_item_t         out_r;
  logic              out_valid_r;

  logic              out_adv;
  logic              proc;
  logic [CNT_W-1:0]  cnt_inc;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign proc        = in_valid_r && out_adv;
  assign in_ch.ready = !in_valid_r || out_adv;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid             = out_valid_r;
  assign out_ch.overcurrent_fault = out_r.overcurrent_fault;
  assign out_ch.open_load         = out_r.open_load;
  assign out_ch.latency_ms        = out_r.latency_ms;
  assign out_ch.battery_at_fault  = out_r.battery_at_fault;
  assign out_ch.fault_active      = out_r.fault_active;

  assign cnt_inc = (debounce_count_r != '1) ? debounce_count_r + CNT_W'(1) : debounce_count_r;

  always_comb begin
    confirmed_nxt      = confirmed_r;
    debounce_count_nxt = debounce_count_r;
    judged_nxt         = judged_r;
    oc_flag_nxt        = oc_flag_r;
    ol_flag_nxt        = ol_flag_r;
    latency_nxt        = latency_r;
    battery_nxt        = battery_r;
    run_time_nxt       = run_time_r;
    run_enable_nxt     = run_enable_r;
    case (in_r.func)
      FUNC_TICK: begin
        // counter advances first, fault capture sees the new value
        if (run_enable_r && run_time_r != '1) begin
          run_time_nxt = run_time_r + TIME_W'(1);
        end
        if (!in_r.motor_running) begin
          confirmed_nxt      = 1'b0;
          debounce_count_nxt = '0;
        end else if (in_r.under_volt || in_r.over_volt) begin
          debounce_count_nxt = '0;
        end else if (!in_r.fault_low) begin
          confirmed_nxt      = 1'b0;
          debounce_count_nxt = '0;
        end else if (!confirmed_r) begin
          debounce_count_nxt = cnt_inc;
          if (cnt_inc >= debounce_ticks_r) begin
            confirmed_nxt = 1'b1;
            if (!judged_r) begin
              judged_nxt  = 1'b1;
              latency_nxt = run_time_nxt;
              battery_nxt = in_r.battery_sample;
              if (run_time_nxt < boundary_ms_r) begin
                oc_flag_nxt = 1'b1;
              end else begin
                ol_flag_nxt = 1'b1;
              end
            end
          end
        end
      end
      FUNC_START: begin
        confirmed_nxt      = 1'b0;
        debounce_count_nxt = '0;
        run_time_nxt       = '0;
        run_enable_nxt     = 1'b1;
      end
      FUNC_STOP: begin
        confirmed_nxt      = 1'b0;
        debounce_count_nxt = '0;
        run_time_nxt       = '0;
        run_enable_nxt     = 1'b0;
      end
      FUNC_CLEAR: begin
        oc_flag_nxt        = 1'b0;
        ol_flag_nxt        = 1'b0;
        judged_nxt         = 1'b0;
        confirmed_nxt      = 1'b0;
        debounce_count_nxt = '0;
      end
      default: begin
        confirmed_nxt = confirmed_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_TICKS_RST;
      boundary_ms_r    <= BOUNDARY_MS_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.idx)
        REG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_ch.data[CNT_W-1:0];
        REG_BOUNDARY_MS:    boundary_ms_r    <= cfg_ch.data[TIME_W-1:0];
        default:            boundary_ms_r    <= boundary_ms_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirmed_r      <= 1'b0;
      debounce_count_r <= '0;
      judged_r         <= 1'b0;
      oc_flag_r        <= 1'b0;
      ol_flag_r        <= 1'b0;
      latency_r        <= '0;
      battery_r        <= '0;
      run_time_r       <= '0;
      run_enable_r     <= 1'b0;
    end else if (proc) begin
      confirmed_r      <= confirmed_nxt;
      debounce_count_r <= debounce_count_nxt;
      judged_r         <= judged_nxt;
      oc_flag_r        <= oc_flag_nxt;
      ol_flag_r        <= ol_flag_nxt;
      latency_r        <= latency_nxt;
      battery_r        <= battery_nxt;
      run_time_r       <= run_time_nxt;
      run_enable_r     <= run_enable_nxt;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.func           <= in_ch.func;
      in_r.motor_running  <= in_ch.motor_running;
      in_r.under_volt     <= in_ch.under_volt;
      in_r.over_volt      <= in_ch.over_volt;
      in_r.fault_low      <= in_ch.fault_low;
      in_r.battery_sample <= in_ch.battery_sample;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_r.overcurrent_fault <= oc_flag_nxt;
      out_r.open_load         <= ol_flag_nxt;
      out_r.latency_ms        <= latency_nxt;
      out_r.battery_at_fault  <= battery_nxt;
      out_r.fault_active      <= confirmed_nxt;
    end
  end

`ifndef SYNTHESIS
  a_class_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(oc_flag_r && ol_flag_r))
    else $error("fault classed as both over-current and open load");

  a_judged_flags: assert property (@(posedge clk) disable iff (!rst_n)
    judged_r == (oc_flag_r || ol_flag_r))
    else $error("judged state disagrees with classification flags");

  a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_r.func == FUNC_STOP) |=> (run_time_r == '0 && !run_enable_r))
    else $error("stop did not halt and clear the run counter");

  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> (out_ch.fault_active == confirmed_r && out_ch.latency_ms == latency_r))
    else $error("result register out of step with classifier state");
`endif

endmodule
